// ----- hw/rtl/cht_pkg.sv -----
// Package for the chained hash table engine: transaction payload types,
// operation and status codes. No dependencies.
package cht_pkg;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_FIND   = 2'd1;
    localparam logic [1:0] FUNC_DELETE = 2'd2;
    localparam logic [1:0] FUNC_CLEAR  = 2'd3;

    localparam logic [2:0] STAT_INSERTED  = 3'd0;
    localparam logic [2:0] STAT_UPDATED   = 3'd1;
    localparam logic [2:0] STAT_FOUND     = 3'd2;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [2:0] STAT_POOL_FULL = 3'd4;

    localparam logic [2:0] BUCKET_BITS_RESET = 3'd6;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] hash_code;
        logic [63:0] value_in;
    } cht_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] value_out;
        logic [7:0]  entry_index;
        logic [8:0]  entry_count;
    } cht_out_t;

endpackage

// ----- hw/rtl/cht_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cht_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hw/rtl/cht_front.sv -----
// Front end: holds the bucket setting, accepts transactions, computes the
// bucket index and queues them in a two-entry queue. Depends on cht_pkg.
module cht_front
    import cht_pkg::*;
#(
    parameter int MAX_BUCKETS = 64,
    parameter int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [2:0]    cfg_wr_data,
    input  logic          s_valid,
    output logic          s_ready,
    input  cht_in_t       s_data,
    output logic          q_valid,
    input  logic          q_pop,
    output cht_in_t       q_item,
    output logic [BW-1:0] q_bucket
);
    // Largest usable number of bucket bits, floor(log2(MAX_BUCKETS)).
    localparam int FL = $clog2(MAX_BUCKETS + 1) - 1;

    logic [2:0]    bucket_bits_reg;
    cht_in_t       item_reg [2];
    logic [BW-1:0] bkt_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    count_reg;
    logic [BW-1:0] mask;
    logic          push;

    always_comb begin
        for (int i = 0; i < BW; i++) begin
            mask[i] = (i < int'(bucket_bits_reg)) && (i < FL);
        end
    end

    assign s_ready  = (count_reg != 2'd2);
    assign push     = s_valid && s_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = item_reg[rd_ptr_reg];
    assign q_bucket = bkt_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            item_reg[wr_ptr_reg] <= s_data;
            bkt_reg[wr_ptr_reg]  <= s_data.hash_code[BW-1:0] & mask;
        end
        if (!aresetn) begin
            bucket_bits_reg <= BUCKET_BITS_RESET;
            wr_ptr_reg      <= 1'b0;
            rd_ptr_reg      <= 1'b0;
            count_reg       <= 2'd0;
        end else begin
            if (cfg_wr_en) begin
                bucket_bits_reg <= cfg_wr_data;
            end
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(q_pop);
        end
    end
endmodule

// ----- hw/rtl/cht_back.sv -----
// Back end: walks bucket chains in node memory, updates chains and the
// free list, and holds the result register. Depends on cht_pkg, cht_ram.
module cht_back
    import cht_pkg::*;
#(
    parameter int MAX_BUCKETS = 64,
    parameter int NODE_COUNT  = 256,
    parameter int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic          q_valid,
    output logic          q_pop,
    input  cht_in_t       q_item,
    input  logic [BW-1:0] q_bucket,
    output logic          m_valid,
    input  logic          m_ready,
    output cht_out_t      m_data
);
    localparam int SW  = $clog2(NODE_COUNT + 1);
    localparam int NAW = $clog2(NODE_COUNT);
    localparam logic [SW-1:0] NIL  = SW'(NODE_COUNT);
    localparam logic [SW-1:0] LAST = SW'(NODE_COUNT - 1);
    localparam logic [BW-1:0] LAST_BKT = BW'(MAX_BUCKETS - 1);

    localparam logic [3:0] ST_CLR   = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_HEAD  = 4'd2;
    localparam logic [3:0] ST_NODE  = 4'd3;
    localparam logic [3:0] ST_ALLOC = 4'd4;
    localparam logic [3:0] ST_LINK  = 4'd5;
    localparam logic [3:0] ST_DEL   = 4'd6;
    localparam logic [3:0] ST_DEL2  = 4'd7;

    logic [3:0]    state_reg, state_next;
    logic [BW-1:0] clr_idx_reg, clr_idx_next;
    cht_in_t       op_reg, op_next;
    logic [BW-1:0] bkt_reg, bkt_next;
    logic [SW-1:0] cur_reg, cur_next;
    logic [SW-1:0] prev_reg, prev_next;
    logic [SW-1:0] nxt_reg, nxt_next;
    logic [63:0]   val_reg, val_next;
    logic [SW-1:0] free_reg, free_next;
    logic [SW-1:0] fresh_reg, fresh_next;
    logic [SW-1:0] live_reg, live_next;
    logic          out_valid_reg, out_valid_next;
    cht_out_t      out_reg, out_next;

    logic          head_we;
    logic [BW-1:0] head_waddr;
    logic [SW-1:0] head_wdata, head_rdata;
    logic [NAW-1:0] node_raddr;
    logic          hash_we, value_we, next_we;
    logic [NAW-1:0] hash_waddr, value_waddr, next_waddr;
    logic [63:0]   value_wdata, hash_rdata, value_rdata;
    logic [SW-1:0] next_wdata, next_rdata;
    logic          miss;

    cht_ram #(.WIDTH(SW), .DEPTH(MAX_BUCKETS)) u_head (
        .aclk(aclk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(q_bucket), .rdata(head_rdata)
    );
    cht_ram #(.WIDTH(64), .DEPTH(NODE_COUNT)) u_hash (
        .aclk(aclk), .we(hash_we), .waddr(hash_waddr), .wdata(op_reg.hash_code),
        .raddr(node_raddr), .rdata(hash_rdata)
    );
    cht_ram #(.WIDTH(64), .DEPTH(NODE_COUNT)) u_value (
        .aclk(aclk), .we(value_we), .waddr(value_waddr), .wdata(value_wdata),
        .raddr(node_raddr), .rdata(value_rdata)
    );
    cht_ram #(.WIDTH(SW), .DEPTH(NODE_COUNT)) u_next (
        .aclk(aclk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
        .raddr(node_raddr), .rdata(next_rdata)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        op_next        = op_reg;
        bkt_next       = bkt_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        nxt_next       = nxt_reg;
        val_next       = val_reg;
        free_next      = free_reg;
        fresh_next     = fresh_reg;
        live_next      = live_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        q_pop          = 1'b0;
        head_we        = 1'b0;
        head_waddr     = bkt_reg;
        head_wdata     = NIL;
        hash_we        = 1'b0;
        hash_waddr     = free_reg[NAW-1:0];
        value_we       = 1'b0;
        value_waddr    = cur_reg[NAW-1:0];
        value_wdata    = op_reg.value_in;
        next_we        = 1'b0;
        next_waddr     = cur_reg[NAW-1:0];
        next_wdata     = NIL;
        node_raddr     = cur_reg[NAW-1:0];
        miss           = 1'b0;

        case (state_reg)
            ST_CLR: begin
                head_we      = 1'b1;
                head_waddr   = clr_idx_reg;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_BKT) begin
                    clr_idx_next = '0;
                    state_next   = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_valid && !out_valid_reg) begin
                    q_pop    = 1'b1;
                    op_next  = q_item;
                    bkt_next = q_bucket;
                    prev_next = NIL;
                    if (q_item.func == FUNC_CLEAR) begin
                        free_next      = '0;
                        fresh_next     = '0;
                        live_next      = '0;
                        out_valid_next = 1'b1;
                        out_next       = '{STAT_NOT_FOUND, 64'd0, 8'd0, 9'd0};
                        state_next     = ST_CLR;
                    end else begin
                        state_next = ST_HEAD;
                    end
                end
            end
            ST_HEAD: begin
                if (head_rdata == NIL) begin
                    miss = 1'b1;
                end else begin
                    cur_next   = head_rdata;
                    node_raddr = head_rdata[NAW-1:0];
                    state_next = ST_NODE;
                end
            end
            ST_NODE: begin
                if (hash_rdata == op_reg.hash_code) begin
                    state_next = ST_IDLE;
                    case (op_reg.func)
                        FUNC_INSERT: begin
                            value_we       = 1'b1;
                            out_valid_next = 1'b1;
                            out_next = '{STAT_UPDATED, op_reg.value_in, 8'(cur_reg),
                                         9'(live_reg)};
                        end
                        FUNC_DELETE: begin
                            nxt_next   = next_rdata;
                            val_next   = value_rdata;
                            state_next = ST_DEL;
                        end
                        default: begin
                            out_valid_next = 1'b1;
                            out_next = '{STAT_FOUND, value_rdata, 8'(cur_reg),
                                         9'(live_reg)};
                        end
                    endcase
                end else begin
                    prev_next = cur_reg;
                    if (next_rdata == NIL) begin
                        miss = 1'b1;
                    end else begin
                        cur_next   = next_rdata;
                        node_raddr = next_rdata[NAW-1:0];
                    end
                end
            end
            ST_ALLOC: begin
                // Slots at or above the fill mark were never linked; the next free slot follows.
                if (free_reg >= fresh_reg) begin
                    free_next  = (free_reg == LAST) ? NIL : free_reg + 1'b1;
                    fresh_next = free_reg + 1'b1;
                end else begin
                    free_next = next_rdata;
                end
                hash_we     = 1'b1;
                value_we    = 1'b1;
                value_waddr = free_reg[NAW-1:0];
                next_we     = 1'b1;
                next_waddr  = free_reg[NAW-1:0];
                cur_next    = free_reg;
                live_next   = live_reg + 1'b1;
                out_valid_next = 1'b1;
                out_next = '{STAT_INSERTED, op_reg.value_in, 8'(free_reg),
                             9'(live_reg + 1'b1)};
                if (prev_reg == NIL) begin
                    head_we    = 1'b1;
                    head_wdata = free_reg;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_LINK;
                end
            end
            ST_LINK: begin
                next_we    = 1'b1;
                next_waddr = prev_reg[NAW-1:0];
                next_wdata = cur_reg;
                state_next = ST_IDLE;
            end
            ST_DEL: begin
                next_we    = 1'b1;
                next_wdata = free_reg;
                free_next  = cur_reg;
                if (live_reg != '0) begin
                    live_next = live_reg - 1'b1;
                end
                out_valid_next = 1'b1;
                out_next = '{STAT_FOUND, val_reg, 8'(cur_reg), 9'(live_next)};
                if (prev_reg == NIL) begin
                    head_we    = 1'b1;
                    head_wdata = nxt_reg;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_DEL2;
                end
            end
            ST_DEL2: begin
                next_we    = 1'b1;
                next_waddr = prev_reg[NAW-1:0];
                next_wdata = nxt_reg;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_CLR;
            end
        endcase

        // End of chain without a match.
        if (miss) begin
            state_next = ST_IDLE;
            if (op_reg.func == FUNC_INSERT && free_reg != NIL) begin
                node_raddr = free_reg[NAW-1:0];
                state_next = ST_ALLOC;
            end else begin
                out_valid_next = 1'b1;
                out_next = '{(op_reg.func == FUNC_INSERT) ? STAT_POOL_FULL : STAT_NOT_FOUND,
                             64'd0, 8'd0, 9'(live_reg)};
            end
        end

        if (cfg_wr_en) begin
            free_next    = '0;
            fresh_next   = '0;
            live_next    = '0;
            clr_idx_next = '0;
            state_next   = ST_CLR;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        bkt_reg  <= bkt_next;
        cur_reg  <= cur_next;
        prev_reg <= prev_next;
        nxt_reg  <= nxt_next;
        val_reg  <= val_next;
        out_reg  <= out_next;
        if (!aresetn) begin
            state_reg     <= ST_CLR;
            clr_idx_reg   <= '0;
            free_reg      <= '0;
            fresh_reg     <= '0;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            free_reg      <= free_next;
            fresh_reg     <= fresh_next;
            live_reg      <= live_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= fresh_reg)
        else $error("live count exceeds allocated slots");
    a_fresh_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fresh_reg <= NIL)
        else $error("fill mark beyond pool");
    a_full_nil: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ALLOC) |-> (free_reg != NIL))
        else $error("allocation from an empty free list");
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> out_valid_reg && $stable(out_reg))
        else $error("pending result overwritten");
`endif
endmodule

// ----- hw/rtl/chained_hash_table_engine_unit.sv -----
// Top level of the chained hash table engine: front end, queue and chain
// walking back end. Depends on cht_pkg, cht_front, cht_back, cht_ram.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    cht_in_t  {func, hash_code, value_in}
//   m_       out        m_valid/m_ready    cht_out_t {status, value_out,
//                                                     entry_index, entry_count}
//   cfg_     in         cfg_wr_en          cfg_wr_data = bucket_bits
//
// In the back end a transaction is popped, reads its bucket head, then
// visits chain nodes (one node memory read per cycle); a new entry or a
// delete adds an allocation or unlink state, and a second write, if any,
// overlaps the result. Clear, reset and any write of the bucket setting
// start a clearing pass over all MAX_BUCKETS bucket head entries, during
// which no new transaction is started. The front queue holds two
// transactions, taken in while a result waits in the output register.
module chained_hash_table_engine_unit
    import cht_pkg::*;
#(
    parameter int MAX_BUCKETS = 64,
    parameter int NODE_COUNT  = 256
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     cfg_wr_en,
    input  logic [2:0] cfg_wr_data,
    input  logic     s_valid,
    output logic     s_ready,
    input  cht_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output cht_out_t m_data
);
    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;

    // Queue between the front end and the back end.
    logic          q_valid, q_pop;
    cht_in_t       q_item;
    logic [BW-1:0] q_bucket;

    cht_front #(.MAX_BUCKETS(MAX_BUCKETS), .BW(BW)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item), .q_bucket(q_bucket)
    );

    // The back end owns the table; a bucket setting write empties it.
    cht_back #(.MAX_BUCKETS(MAX_BUCKETS), .NODE_COUNT(NODE_COUNT), .BW(BW)) u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en),
        .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item), .q_bucket(q_bucket),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );
endmodule
